[rtl/fbpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, constants and microcode for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int AddrW     = 32;
  localparam int SizeW     = 16;
  localparam int BsW       = 17;
  localparam int CntW      = 9;
  localparam int FuncW     = 2;
  localparam int CfgIdxW   = 2;
  localparam int ALIGN     = 16;
  localparam int ADDR_BITS = 32;
  localparam int UpcW      = 5;

  localparam logic [FuncW-1:0] FuncInit  = 2'd0;
  localparam logic [FuncW-1:0] FuncAlloc = 2'd1;
  localparam logic [FuncW-1:0] FuncFree  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSize  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCount = 2'd2;

  localparam logic [AddrW-1:0] CfgBaseRst  = 32'h0001_0000;
  localparam logic [SizeW-1:0] CfgSizeRst  = 16'd16;
  localparam logic [CntW-1:0]  CfgCountRst = 9'd256;

  typedef logic [UpcW-1:0] upc_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NULL,
    ST_BADARG,
    ST_OVERFLOW,
    ST_NOMEM,
    ST_BADSTATE
  } status_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_INIT_MUL,
    UOP_SUM_CFG,
    UOP_INIT_START,
    UOP_INIT_LINK,
    UOP_RD_HEAD,
    UOP_POP,
    UOP_FREE_MUL,
    UOP_SUM_END,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_PUSH,
    UOP_FINISH,
    UOP_FIN_GRANT
  } uop_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_FUNC_INIT,
    C_FUNC_ALLOC,
    C_FUNC_FREE,
    C_ARG_BAD,
    C_OVF,
    C_LINK_MORE,
    C_NO_HEAD,
    C_ADDR_ZERO,
    C_RANGE_BAD,
    C_DIV_MORE,
    C_REM_NZ,
    C_FULL
  } cond_e;

  typedef struct packed {
    uop_e    op;
    cond_e   cond;
    upc_t    target;
    status_e st;
  } uword_t;

  typedef struct packed {
    logic func_init;
    logic func_alloc;
    logic func_free;
    logic arg_bad;
    logic ovf;
    logic link_more;
    logic no_head;
    logic addr_zero;
    logic range_bad;
    logic div_more;
    logic rem_nz;
    logic full;
  } flags_t;

  // jump targets
  localparam upc_t UpcBadArg   = 5'd3;
  localparam upc_t UpcInit     = 5'd4;
  localparam upc_t UpcLink     = 5'd8;
  localparam upc_t UpcOvf      = 5'd10;
  localparam upc_t UpcAlloc    = 5'd11;
  localparam upc_t UpcNoMem    = 5'd14;
  localparam upc_t UpcFree     = 5'd15;
  localparam upc_t UpcDiv      = 5'd18;
  localparam upc_t UpcNull     = 5'd23;
  localparam upc_t UpcBadState = 5'd24;
  localparam upc_t UpcLast     = 5'd24;

  function automatic uword_t uw(uop_e op, cond_e cond, upc_t target, status_e st);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.st     = st;
    return w;
  endfunction

  function automatic uword_t ucode(upc_t upc);
    uword_t w;
    unique case (upc)
      // dispatch
      5'd0:  w = uw(UOP_NOP,        C_FUNC_INIT,  UpcInit,     ST_OK);
      5'd1:  w = uw(UOP_NOP,        C_FUNC_ALLOC, UpcAlloc,    ST_OK);
      5'd2:  w = uw(UOP_NOP,        C_FUNC_FREE,  UpcFree,     ST_OK);
      5'd3:  w = uw(UOP_FINISH,     C_NONE,       '0,          ST_BADARG);
      // init
      5'd4:  w = uw(UOP_INIT_MUL,   C_ARG_BAD,    UpcBadArg,   ST_OK);
      5'd5:  w = uw(UOP_SUM_CFG,    C_NONE,       '0,          ST_OK);
      5'd6:  w = uw(UOP_NOP,        C_OVF,        UpcOvf,      ST_OK);
      5'd7:  w = uw(UOP_INIT_START, C_NONE,       '0,          ST_OK);
      5'd8:  w = uw(UOP_INIT_LINK,  C_LINK_MORE,  UpcLink,     ST_OK);
      5'd9:  w = uw(UOP_FINISH,     C_NONE,       '0,          ST_OK);
      5'd10: w = uw(UOP_FINISH,     C_NONE,       '0,          ST_OVERFLOW);
      // alloc
      5'd11: w = uw(UOP_RD_HEAD,    C_NO_HEAD,    UpcNoMem,    ST_OK);
      5'd12: w = uw(UOP_POP,        C_NONE,       '0,          ST_OK);
      5'd13: w = uw(UOP_FIN_GRANT,  C_NONE,       '0,          ST_OK);
      5'd14: w = uw(UOP_FINISH,     C_NONE,       '0,          ST_NOMEM);
      // free
      5'd15: w = uw(UOP_FREE_MUL,   C_ADDR_ZERO,  UpcNull,     ST_OK);
      5'd16: w = uw(UOP_SUM_END,    C_NONE,       '0,          ST_OK);
      5'd17: w = uw(UOP_DIV_INIT,   C_RANGE_BAD,  UpcBadArg,   ST_OK);
      5'd18: w = uw(UOP_DIV_STEP,   C_DIV_MORE,   UpcDiv,      ST_OK);
      5'd19: w = uw(UOP_NOP,        C_REM_NZ,     UpcBadArg,   ST_OK);
      5'd20: w = uw(UOP_NOP,        C_FULL,       UpcBadState, ST_OK);
      5'd21: w = uw(UOP_PUSH,       C_NONE,       '0,          ST_OK);
      5'd22: w = uw(UOP_FINISH,     C_NONE,       '0,          ST_OK);
      5'd23: w = uw(UOP_FINISH,     C_NONE,       '0,          ST_NULL);
      5'd24: w = uw(UOP_FINISH,     C_NONE,       '0,          ST_BADSTATE);
      default: w = uw(UOP_FINISH,   C_NONE,       '0,          ST_BADARG);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/fixed_block_pool_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool allocator with a LIFO free list of block indices.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its result is
// shown for exactly one cycle with done_o, and the receiver cannot stall it.
// A microcoded sequencer runs one step per cycle, and busy stays high through
// the done cycle, so the next request can enter on the cycle after done_o.
// On a free, the block index is found by a restoring divider, one quotient
// bit per cycle; early errors end a request before its full sequence. Init
// writes one free list link per cycle through the single RAM write port.
// Configuration writes are always ready and are to be made while idle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] block_address_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_address_o,
  output logic [8:0]  blocks_free_o
);
  import fbpa_pkg::*;

  uop_e   uop;
  flags_t flags;

  assign cfg_ready_o = 1'b1;

  fbpa_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .flags_i (flags),
    .uop_o   (uop),
    .done_o  (done_o),
    .status_o(status_o)
  );

  fbpa_dp #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .block_address_i  (block_address_i),
    .uop_i            (uop),
    .flags_o          (flags),
    .granted_address_o(granted_address_o),
    .blocks_free_o    (blocks_free_o)
  );

endmodule
`default_nettype wire

[rtl/fbpa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/fbpa_useq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module fbpa_useq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  fbpa_pkg::flags_t               flags_i,
  output fbpa_pkg::uop_e                 uop_o,
  output logic                           done_o,
  output logic [2:0]                     status_o
);
  import fbpa_pkg::*;

  logic   running_q;
  upc_t   upc_q;
  uword_t word;
  logic   hit;
  logic   finish;

  assign word = ucode(upc_q);

  always_comb begin
    unique case (word.cond)
      C_NONE:       hit = 1'b0;
      C_FUNC_INIT:  hit = flags_i.func_init;
      C_FUNC_ALLOC: hit = flags_i.func_alloc;
      C_FUNC_FREE:  hit = flags_i.func_free;
      C_ARG_BAD:    hit = flags_i.arg_bad;
      C_OVF:        hit = flags_i.ovf;
      C_LINK_MORE:  hit = flags_i.link_more;
      C_NO_HEAD:    hit = flags_i.no_head;
      C_ADDR_ZERO:  hit = flags_i.addr_zero;
      C_RANGE_BAD:  hit = flags_i.range_bad;
      C_DIV_MORE:   hit = flags_i.div_more;
      C_REM_NZ:     hit = flags_i.rem_nz;
      C_FULL:       hit = flags_i.full;
      default:      hit = 1'b0;
    endcase
  end

  assign finish   = running_q && (word.op == UOP_FINISH || word.op == UOP_FIN_GRANT);
  assign done_o   = finish;
  assign busy     = running_q;
  assign status_o = 3'(word.st);

  always_comb begin
    if (running_q) begin
      uop_o = word.op;
    end else if (start) begin
      uop_o = UOP_LOAD;
    end else begin
      uop_o = UOP_NOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      upc_q     <= '0;
    end else if (!running_q) begin
      if (start) begin
        running_q <= 1'b1;
        upc_q     <= '0;
      end
    end else if (finish) begin
      running_q <= 1'b0;
    end else if (hit) begin
      upc_q <= word.target;
    end else begin
      upc_q <= upc_q + 1'b1;
    end
  end

  a_start_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && upc_q == '0))
    else $error("request not taken into step zero");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_upc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (upc_q <= UpcLast))
    else $error("step counter outside program");

endmodule
`default_nettype wire

[rtl/fbpa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: config registers, pool state, multiplier, adder, divider
// registers and the free list RAM, driven one micro-op per cycle.
// ----------------------------------------------------------------------------
module fbpa_dp #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic [1:0]                     func_i,
  input  logic [31:0]                    block_address_i,
  input  fbpa_pkg::uop_e                 uop_i,
  output fbpa_pkg::flags_t               flags_o,
  output logic [31:0]                    granted_address_o,
  output logic [8:0]                     blocks_free_o
);
  import fbpa_pkg::*;

  localparam int IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NW    = (IdxW > CntW) ? IdxW : CntW;
  localparam int PW    = BsW + NW;
  localparam int SumW  = ((PW > AddrW) ? PW : AddrW) + 1;
  localparam int DivW  = BsW + CntW - 1;
  localparam int LinkW = IdxW + 1;
  localparam int AlignMask = ALIGN - 1;
  localparam logic [SumW-1:0] SumLimit =
    (ADDR_BITS < SumW) ? (SumW'(1) << ADDR_BITS) : '1;

  // config
  logic [AddrW-1:0] cfg_base_q;
  logic [SizeW-1:0] cfg_size_q;
  logic [CntW-1:0]  cfg_count_q;
  // pool state
  logic [AddrW-1:0] base_q;
  logic [BsW-1:0]   bs_q;
  logic [CntW-1:0]  total_q;
  logic [CntW-1:0]  free_q;
  logic [IdxW-1:0]  head_q;
  logic             head_ok_q;
  // working
  logic [FuncW-1:0] func_q;
  logic [AddrW-1:0] addr_q;
  logic [BsW-1:0]   bsnew_q;
  logic [PW-1:0]    prod_q;
  logic [SumW-1:0]  sum_q;
  logic [AddrW-1:0] rem_q;
  logic [DivW-1:0]  div_q;
  logic [NW-1:0]    quo_q;
  logic [NW-1:0]    cnt_q;

  logic [BsW-1:0]   rnd;
  logic [BsW-1:0]   mul_a;
  logic [NW-1:0]    mul_b;
  logic [PW-1:0]    mul;
  logic [SumW-1:0]  add_a;
  logic [SumW-1:0]  sum;
  logic             div_ge;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [LinkW-1:0] ram_wdata;
  logic [LinkW-1:0] ram_rdata;

  assign rnd = (BsW'(cfg_size_q) + BsW'(AlignMask)) & ~BsW'(AlignMask);

  always_comb begin
    unique case (uop_i)
      UOP_INIT_MUL: begin
        mul_a = rnd;
        mul_b = NW'(cfg_count_q);
      end
      UOP_RD_HEAD: begin
        mul_a = bs_q;
        mul_b = NW'(head_q);
      end
      default: begin
        mul_a = bs_q;
        mul_b = NW'(total_q);
      end
    endcase
  end

  assign mul   = PW'(mul_a) * PW'(mul_b);
  assign add_a = (uop_i == UOP_SUM_CFG) ? SumW'(cfg_base_q) : SumW'(base_q);
  assign sum   = add_a + SumW'(prod_q);
  assign div_ge = rem_q >= AddrW'(div_q);

  assign ram_we    = (uop_i == UOP_INIT_LINK) || (uop_i == UOP_PUSH);
  assign ram_waddr = (uop_i == UOP_INIT_LINK) ? cnt_q[IdxW-1:0] : quo_q[IdxW-1:0];
  assign ram_wdata = (uop_i == UOP_INIT_LINK) ?
                     {(cnt_q != '0), IdxW'(cnt_q - 1'b1)} : {head_ok_q, head_q};

  fbpa_ram #(
    .Width(LinkW),
    .Depth(MAX_BLOCKS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign flags_o.func_init  = func_q == FuncInit;
  assign flags_o.func_alloc = func_q == FuncAlloc;
  assign flags_o.func_free  = func_q == FuncFree;
  assign flags_o.arg_bad    = (cfg_size_q == '0) || (cfg_count_q == '0) ||
                              (32'(cfg_count_q) > 32'(MAX_BLOCKS));
  assign flags_o.ovf        = sum_q > SumLimit;
  assign flags_o.link_more  = ({1'b0, cnt_q} + 1'b1) != (NW + 1)'(total_q);
  assign flags_o.no_head    = !head_ok_q;
  assign flags_o.addr_zero  = addr_q == '0;
  assign flags_o.range_bad  = (addr_q < base_q) || (SumW'(addr_q) >= sum_q) ||
                              (bs_q == '0);
  assign flags_o.div_more   = cnt_q != NW'(CntW - 1);
  assign flags_o.rem_nz     = rem_q != '0;
  assign flags_o.full       = free_q == total_q;

  assign granted_address_o = (uop_i == UOP_FIN_GRANT) ? sum_q[AddrW-1:0] : '0;
  assign blocks_free_o     = free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= CfgBaseRst;
      cfg_size_q  <= CfgSizeRst;
      cfg_count_q <= CfgCountRst;
      base_q      <= '0;
      bs_q        <= '0;
      total_q     <= '0;
      free_q      <= '0;
      head_q      <= '0;
      head_ok_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgBase:  cfg_base_q  <= cfg_data_i;
          CfgSize:  cfg_size_q  <= cfg_data_i[SizeW-1:0];
          CfgCount: cfg_count_q <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      unique case (uop_i)
        UOP_INIT_START: begin
          base_q    <= cfg_base_q;
          bs_q      <= bsnew_q;
          total_q   <= cfg_count_q;
          free_q    <= cfg_count_q;
          head_q    <= IdxW'(cfg_count_q - 1'b1);
          head_ok_q <= 1'b1;
        end
        UOP_POP: begin
          head_q    <= ram_rdata[IdxW-1:0];
          head_ok_q <= ram_rdata[IdxW];
          if (free_q != '0) begin
            free_q <= free_q - 1'b1;
          end
        end
        UOP_PUSH: begin
          head_q    <= quo_q[IdxW-1:0];
          head_ok_q <= 1'b1;
          free_q    <= free_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uop_i)
      UOP_LOAD: begin
        func_q <= func_i;
        addr_q <= block_address_i;
      end
      UOP_INIT_MUL: begin
        prod_q  <= mul;
        bsnew_q <= rnd;
      end
      UOP_SUM_CFG, UOP_SUM_END, UOP_POP: begin
        sum_q <= sum;
      end
      UOP_INIT_START: begin
        cnt_q <= '0;
      end
      UOP_INIT_LINK: begin
        cnt_q <= cnt_q + 1'b1;
      end
      UOP_RD_HEAD: begin
        prod_q <= mul;
      end
      UOP_FREE_MUL: begin
        prod_q <= mul;
        rem_q  <= addr_q - base_q;
      end
      UOP_DIV_INIT: begin
        div_q <= DivW'(bs_q) << (CntW - 1);
        quo_q <= '0;
        cnt_q <= '0;
      end
      UOP_DIV_STEP: begin
        if (div_ge) begin
          rem_q <= rem_q - AddrW'(div_q);
        end
        quo_q <= {quo_q[NW-2:0], div_ge};
        div_q <= div_q >> 1;
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= total_q)
    else $error("free count above pool size");

  a_push_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_i == UOP_PUSH) |=> (head_ok_q && free_q == $past(free_q) + 1'b1))
    else $error("push did not update head or count");

endmodule
`default_nettype wire
